// File: hdl/u8cells_pkg.sv
// Shared types and constants for the UTF-8 text to clipped cell writer.
package u8cells_pkg;

    // Configuration port geometry
    localparam int AddrWidth = 5;
    localparam int DataWidth = 32;

    // Largest column the cursor can hold; it saturates here
    localparam logic signed [16:0] COL_MAX = 17'sh0FFFF;

    // Character sent for a lead byte that starts no valid sequence
    localparam logic [20:0] CP_BAD_LEAD = 21'h00003F;

    // Register map, word index in paddr[4:2]
    typedef enum logic [2:0] {
        REG_CLIP_X      = 3'd0,
        REG_CLIP_Y      = 3'd1,
        REG_CLIP_WIDTH  = 3'd2,
        REG_CLIP_HEIGHT = 3'd3,
        REG_FG_COLOR    = 3'd4,
        REG_BG_COLOR    = 3'd5,
        REG_STYLE_BITS  = 3'd6
    } reg_idx_t;

    // One input item: a byte of the string plus framing and start position
    typedef struct packed {
        logic [7:0]         text_byte;
        logic               first_of_string;
        logic               last_of_string;
        logic signed [15:0] start_col;
        logic signed [15:0] text_row;
    } text_item_t;

    // One result item: a cell write
    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic [20:0]        code_point;
        logic [23:0]        cell_fg;
        logic [23:0]        cell_bg;
        logic [7:0]         cell_style;
    } cell_item_t;

    // Decoder to clipper: a finished code point and where it lands
    typedef struct packed {
        logic               emit;
        logic [20:0]        code_point;
        logic signed [16:0] col;
        logic signed [15:0] row;
    } dec_cell_t;

    // Clip rectangle
    typedef struct packed {
        logic signed [15:0] clip_x;
        logic signed [15:0] clip_y;
        logic [14:0]        clip_width;
        logic [14:0]        clip_height;
    } clip_cfg_t;

    // Clipper result
    typedef struct packed {
        logic               write;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
    } clip_res_t;

endpackage

// File: hdl/utf8_text_to_clipped_cells.sv
// Top level: UTF-8 string bytes in, clipped character cell writes out.
//
// Usage:
//   text channel: one byte of a UTF-8 string per item, with first/last marks
//   and, on the first byte, the start column and row relative to the clip
//   origin. cell channel: zero or one cell write per byte, carrying absolute
//   screen coordinates, the decoded code point and the configured colors
//   and style. Registers sit on an APB port at byte offsets 0x00..0x18.
// Timing:
//   A byte is taken into an input register at the accepting edge, decoded and
//   clipped from there, and its cell write is loaded into the output register
//   at the edge on which the byte moves on, once the output slot is free.
//   One byte per cycle is sustained while cell_stall is low; the cursor and
//   sequence state update as each byte moves on, which sets that rate.
// Stall:
//   While cell_stall holds a waiting cell, one more byte is still taken into
//   the input register; text_stall rises only when both registers are full.
// Reset:
//   rst_n clears the valid flags, the configuration registers, the cursor
//   (column and row zero) and any pending sequence. Write registers only
//   while the block is idle.
module utf8_text_to_clipped_cells
    import u8cells_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 text_valid,
    output logic                 text_stall,
    input  text_item_t           text_item,

    output logic                 cell_valid,
    input  logic                 cell_stall,
    output cell_item_t           cell_item,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready
);

    // Configuration registers
    clip_cfg_t   clip_cfg_reg;
    logic [23:0] fg_color_reg;
    logic [23:0] bg_color_reg;
    logic [7:0]  style_bits_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;

    // Pipeline registers
    logic        s1_valid_reg, s1_valid_next;
    text_item_t  s1_item_reg;
    logic        out_valid_reg, out_valid_next;
    cell_item_t  out_item_reg;

    logic        text_accept;
    logic        s1_go;
    dec_cell_t   dec_cell;
    clip_res_t   clip_res;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_cfg_reg   <= '0;
            fg_color_reg   <= '0;
            bg_color_reg   <= '0;
            style_bits_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_CLIP_X:      clip_cfg_reg.clip_x      <= pwdata[15:0];
                REG_CLIP_Y:      clip_cfg_reg.clip_y      <= pwdata[15:0];
                REG_CLIP_WIDTH:  clip_cfg_reg.clip_width  <= pwdata[14:0];
                REG_CLIP_HEIGHT: clip_cfg_reg.clip_height <= pwdata[14:0];
                REG_FG_COLOR:    fg_color_reg             <= pwdata[23:0];
                REG_BG_COLOR:    bg_color_reg             <= pwdata[23:0];
                REG_STYLE_BITS:  style_bits_reg           <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_CLIP_X:      prdata = {16'd0, clip_cfg_reg.clip_x};
            REG_CLIP_Y:      prdata = {16'd0, clip_cfg_reg.clip_y};
            REG_CLIP_WIDTH:  prdata = {17'd0, clip_cfg_reg.clip_width};
            REG_CLIP_HEIGHT: prdata = {17'd0, clip_cfg_reg.clip_height};
            REG_FG_COLOR:    prdata = {8'd0, fg_color_reg};
            REG_BG_COLOR:    prdata = {8'd0, bg_color_reg};
            REG_STYLE_BITS:  prdata = {24'd0, style_bits_reg};
            default:         prdata = '0;
        endcase
    end

    // Handshake: the held byte moves on when the output slot is free
    assign s1_go       = s1_valid_reg && (!out_valid_reg || !cell_stall);
    assign text_stall  = s1_valid_reg && !s1_go;
    assign text_accept = text_valid && !text_stall;

    always_comb
    begin
        if (text_accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_go)
            out_valid_next = clip_res.write;
        else if (!cell_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (text_accept)
            s1_item_reg <= text_item;
        if (s1_go && clip_res.write)
        begin
            out_item_reg.screen_x   <= clip_res.screen_x;
            out_item_reg.screen_y   <= clip_res.screen_y;
            out_item_reg.code_point <= dec_cell.code_point;
            out_item_reg.cell_fg    <= fg_color_reg;
            out_item_reg.cell_bg    <= bg_color_reg;
            out_item_reg.cell_style <= style_bits_reg;
        end
    end

    u8cells_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (s1_go),
        .item  (s1_item_reg),
        .dcell (dec_cell)
    );

    u8cells_clip u_clip (
        .dcell (dec_cell),
        .cfg   (clip_cfg_reg),
        .res   (clip_res)
    );

    assign cell_valid = out_valid_reg;
    assign cell_item  = out_item_reg;

    // A new cell only ever comes from a byte processed the cycle before
    a_cell_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cell_valid) |-> $past(s1_go))
        else $error("cell appeared without a processed byte");

    // Input stalls only when the input register holds a byte
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    // A stalled cell is never overwritten by a processed byte
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cell_stall) |-> !s1_go)
        else $error("waiting cell overwritten");

endmodule

// File: hdl/u8cells_decode.sv
// UTF-8 decoder with cursor state: column, row, partial code point, bytes pending.
module u8cells_decode
    import u8cells_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  text_item_t item,
    output dec_cell_t  dcell
);

    logic signed [16:0] col_reg, col_next;
    logic signed [15:0] row_reg, row_next;
    logic [20:0]        part_reg, part_next;
    logic [1:0]         rem_reg, rem_next;

    logic signed [16:0] col_base;
    logic signed [15:0] row_base;
    logic [20:0]        part_base;
    logic [1:0]         rem_base;
    logic [1:0]         rem_dec;
    logic [20:0]        cont_bits;
    logic [7:0]         b;

    // First byte restarts the cursor and drops any pending sequence
    always_comb
    begin
        b         = item.text_byte;
        col_base  = item.first_of_string ? {item.start_col[15], item.start_col} : col_reg;
        row_base  = item.first_of_string ? item.text_row : row_reg;
        part_base = item.first_of_string ? '0 : part_reg;
        rem_base  = item.first_of_string ? 2'd0 : rem_reg;
        rem_dec   = rem_base - 2'd1;
    end

    // Place the low six bits of a continuation byte
    always_comb
    begin
        case (rem_dec)
            2'd0:    cont_bits = {15'd0, b[5:0]};
            2'd1:    cont_bits = {9'd0, b[5:0], 6'd0};
            2'd2:    cont_bits = {3'd0, b[5:0], 12'd0};
            default: cont_bits = '0;
        endcase
    end

    // Decode step
    always_comb
    begin
        part_next        = part_base;
        rem_next         = rem_base;
        dcell.emit       = 1'b0;
        dcell.code_point = '0;
        dcell.col        = col_base;
        dcell.row        = row_base;
        if (rem_base != 2'd0)
        begin
            part_next        = part_base | cont_bits;
            dcell.code_point = part_next;
            if (rem_dec == 2'd0 || item.last_of_string)
            begin
                dcell.emit = 1'b1;
                rem_next   = 2'd0;
            end
            else
            begin
                rem_next = rem_dec;
            end
        end
        else if (!b[7])
        begin
            dcell.emit       = 1'b1;
            dcell.code_point = {13'd0, b};
        end
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
        begin
            if (b[7:5] == 3'b110)
            begin
                part_next = {10'd0, b[4:0], 6'd0};
                rem_next  = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                part_next = {5'd0, b[3:0], 12'd0};
                rem_next  = 2'd2;
            end
            else
            begin
                part_next = {b[2:0], 18'd0};
                rem_next  = 2'd3;
            end
            // string ends right after the lead byte: flush what we have
            if (item.last_of_string)
            begin
                dcell.emit       = 1'b1;
                dcell.code_point = part_next;
                rem_next         = 2'd0;
            end
        end
        else
        begin
            dcell.emit       = 1'b1;
            dcell.code_point = CP_BAD_LEAD;
        end
    end

    // Cursor advance, saturating
    always_comb
    begin
        row_next = row_base;
        if (dcell.emit && col_base != COL_MAX)
            col_next = col_base + 17'sd1;
        else
            col_next = col_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            part_reg <= '0;
            rem_reg  <= '0;
        end
        else if (go)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            part_reg <= part_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

// File: hdl/u8cells_clip.sv
// Clip test and screen coordinate sums for one decoded code point.
module u8cells_clip
    import u8cells_pkg::*;
(
    input  dec_cell_t  dcell,
    input  clip_cfg_t  cfg,
    output clip_res_t  res
);

    logic signed [17:0] sx;
    logic signed [16:0] sy;
    logic               in_x;
    logic               in_y;
    logic               fits;

    // Sums one bit wider than the operands, then range checks
    always_comb
    begin
        sx   = {cfg.clip_x[15], cfg.clip_x[15], cfg.clip_x} + {dcell.col[16], dcell.col};
        sy   = {cfg.clip_y[15], cfg.clip_y} + {dcell.row[15], dcell.row};
        in_x = !dcell.col[16] && (dcell.col[15:0] < {1'b0, cfg.clip_width});
        in_y = !dcell.row[15] && (dcell.row[14:0] < cfg.clip_height);
        fits = (sx[17:15] == 3'b000 || sx[17:15] == 3'b111) && (sy[16] == sy[15]);
        res.write    = dcell.emit && in_x && in_y && fits;
        res.screen_x = sx[15:0];
        res.screen_y = sy[15:0];
    end

endmodule
